@@ rtl/sorted_unique_set_macros.svh @@
// Assertion helpers shared by the sorted set RTL.
// Every check samples on clk and is held off while arst_n is low.
`ifndef SORTED_UNIQUE_SET_MACROS_SVH
`define SORTED_UNIQUE_SET_MACROS_SVH

// Same-cycle implication.
`define SUS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SUS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sus_pkg.sv @@
`timescale 1ns / 1ps

package sus_pkg;

	localparam int unsigned CAPACITY_DEF    = 16;
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_POP    = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] item_value;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic [2:0]         status;
		logic [4:0]         entry_count;
	} rsp_item_t;

	// RAM read address source
	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX_DN,
		RD_IDX_UP
	} rd_sel_t;

	// RAM write data source
	typedef enum logic {
		WR_RD_DATA,
		WR_VAL
	} wr_sel_t;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_INC,
		IDX_DEC,
		IDX_CNT
	} idx_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		idx_op_t idx_op;
		logic    pos_take;
		logic    res_take;
		logic    stat_set;
		status_t stat_code;
		cnt_op_t cnt_op;
	} dp_cmd_t;

	typedef struct packed {
		action_t act;
		logic    cnt_zero;
		logic    full;
		logic    idx_at_end;
		logic    less;
		logic    equal;
		logic    idx_gt_pos;
		logic    idx_up_lt_cnt;
	} dp_stat_t;

endpackage

@@ rtl/sorted_unique_set.sv @@
// Sorted set of up to CAPACITY unique signed values, one result item per request item.
// Clear, or remove or pop on an empty set: S_DECIDE, S_FINISH, then the output register.
// An insert or remove may walk the whole set: it searches, then shifts entries.
// Search and shifting share one RAM read port: a read, then a compare or write, per entry.
// Throughput: one item in flight; the next is taken once the result is in the output register.
// Reset (arst_n low, async): count cleared to zero, no item held; RAM contents are not cleared.
`timescale 1ns / 1ps

module sorted_unique_set
	import sus_pkg::*;
#(
	parameter int unsigned CAPACITY    = CAPACITY_DEF,
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req_item,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp_item
);

	`include "sorted_unique_set_macros.svh"

	dp_cmd_t   cmd;
	dp_stat_t  stat;
	rsp_item_t result;
	logic      idle;
	logic      done;
	logic      req_fire;
	logic      out_free;
	logic      rsp_valid_q;
	rsp_item_t rsp_item_q;

	// the controller only takes an item when idle; the output register
	// lets it take the next one while the last result still waits
	assign req_ready = idle;
	assign req_fire  = req_valid && idle;
	assign out_free  = !rsp_valid_q || rsp_ready;

	sus_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_fire (req_fire),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd),
		.idle     (idle),
		.done     (done)
	);

	sus_datapath #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_item (req_item),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result)
	);

	// output register: loaded on done, which only fires when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_item_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	`SUS_ASSERT_NXT(a_busy_after_take, req_fire, !req_ready, "item taken while busy")
	`SUS_ASSERT_IMP(a_no_overwrite, done, !rsp_valid_q || rsp_ready, "result overwritten")

endmodule

@@ rtl/sus_ram.sv @@
`timescale 1ns / 1ps

module sus_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/sus_datapath.sv @@
`timescale 1ns / 1ps

module sus_datapath
	import sus_pkg::*;
#(
	parameter int unsigned CAPACITY    = CAPACITY_DEF,
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req_item,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	output rsp_item_t result
);

	`include "sorted_unique_set_macros.svh"

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned IDX_W = $clog2(CAPACITY);

	logic [VALUE_WIDTH-1:0] val_q;
	logic [VALUE_WIDTH-1:0] res_q;
	action_t                act_q;
	status_t                stat_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       idx_q;
	logic [CNT_W-1:0]       pos_q;

	logic [CNT_W-1:0]       idx_dn;
	logic [CNT_W:0]         idx_up;
	logic [CNT_W-1:0]       rd_idx;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic [VALUE_WIDTH-1:0] wr_data;

	assign idx_dn  = idx_q - CNT_W'(1);
	assign idx_up  = {1'b0, idx_q} + (CNT_W + 1)'(1);

	always_comb begin
		case (cmd.rd_sel)
			RD_IDX_DN: rd_idx = idx_dn;
			RD_IDX_UP: rd_idx = idx_up[CNT_W-1:0];
			default:   rd_idx = idx_q;
		endcase
	end

	assign wr_data = (cmd.wr_sel == WR_VAL) ? val_q : rd_data;

	sus_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (idx_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_idx[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// item value and result are stored as raw bits; order is signed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= VALUE_WIDTH'($unsigned(req_item.item_value));
			act_q <= action_t'(req_item.action);
		end
		if (cmd.load) begin
			res_q <= '0;
		end else if (cmd.res_take) begin
			res_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			pos_q  <= '0;
			stat_q <= ST_OK;
		end else begin
			if (cmd.load) begin
				stat_q <= ST_OK;
			end else if (cmd.stat_set) begin
				stat_q <= cmd.stat_code;
			end

			if (cmd.load) begin
				idx_q <= '0;
			end else begin
				case (cmd.idx_op)
					IDX_INC: idx_q <= idx_up[CNT_W-1:0];
					IDX_DEC: idx_q <= idx_dn;
					IDX_CNT: idx_q <= cnt_q;
					default: idx_q <= idx_q;
				endcase
			end

			if (cmd.pos_take) begin
				pos_q <= idx_q;
			end

			case (cmd.cnt_op)
				CNT_INC: cnt_q <= cnt_q + CNT_W'(1);
				CNT_DEC: cnt_q <= cnt_q - CNT_W'(1);
				CNT_CLR: cnt_q <= '0;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign stat.act           = act_q;
	assign stat.cnt_zero      = (cnt_q == '0);
	assign stat.full          = (cnt_q == CNT_W'(CAPACITY));
	assign stat.idx_at_end    = (idx_q == cnt_q);
	assign stat.less          = ($signed(rd_data) < $signed(val_q));
	assign stat.equal         = (rd_data == val_q);
	assign stat.idx_gt_pos    = (idx_q > pos_q);
	assign stat.idx_up_lt_cnt = (idx_up < {1'b0, cnt_q});

	assign result.out_value   = 32'(res_q);
	assign result.status      = stat_q;
	assign result.entry_count = 5'(cnt_q);

	`SUS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
	`SUS_ASSERT_NXT(a_clr_empties, cmd.cnt_op == CNT_CLR, cnt_q == '0, "clear left entries")
	`SUS_ASSERT_IMP(a_wr_in_range, cmd.wr_en, idx_q < CNT_W'(CAPACITY), "write past last entry")

endmodule

@@ rtl/sus_ctrl.sv @@
`timescale 1ns / 1ps

module sus_ctrl
	import sus_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_fire,
	input  logic     out_free,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     idle,
	output logic     done
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_SCAN_EV,
		S_SHUP,
		S_SHUP_WR,
		S_POP_EV,
		S_SHDN,
		S_SHDN_WR,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   resolve;
	logic   found;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		idle    = 1'b0;
		done    = 1'b0;
		resolve = 1'b0;
		found   = 1'b0;

		case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (req_fire) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (stat.act)
					ACT_INSERT: state_d = S_SCAN;
					ACT_REMOVE: begin
						if (stat.cnt_zero) begin
							cmd.stat_set  = 1'b1;
							cmd.stat_code = ST_EMPTY;
							state_d       = S_FINISH;
						end else begin
							state_d = S_SCAN;
						end
					end
					ACT_POP: begin
						if (stat.cnt_zero) begin
							cmd.stat_set  = 1'b1;
							cmd.stat_code = ST_EMPTY;
							state_d       = S_FINISH;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_IDX;
							state_d    = S_POP_EV;
						end
					end
					ACT_CLEAR: begin
						cmd.cnt_op = CNT_CLR;
						state_d    = S_FINISH;
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_SCAN: begin
				if (stat.idx_at_end) begin
					cmd.pos_take = 1'b1;
					resolve      = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
					state_d    = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				if (stat.less) begin
					cmd.idx_op = IDX_INC;
					state_d    = S_SCAN;
				end else begin
					cmd.pos_take = 1'b1;
					resolve      = 1'b1;
					found        = stat.equal;
				end
			end
			S_SHUP: begin
				if (stat.idx_gt_pos) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_DN;
					state_d    = S_SHUP_WR;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_VAL;
					cmd.cnt_op = CNT_INC;
					state_d    = S_FINISH;
				end
			end
			S_SHUP_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_RD_DATA;
				cmd.idx_op = IDX_DEC;
				state_d    = S_SHUP;
			end
			S_POP_EV: begin
				cmd.res_take = 1'b1;
				state_d      = S_SHDN;
			end
			S_SHDN: begin
				if (stat.idx_up_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_UP;
					state_d    = S_SHDN_WR;
				end else begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_FINISH;
				end
			end
			S_SHDN_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_RD_DATA;
				cmd.idx_op = IDX_INC;
				state_d    = S_SHDN;
			end
			S_FINISH: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// end of search: position known, decide the outcome
		if (resolve) begin
			if (stat.act == ACT_INSERT) begin
				if (found) begin
					cmd.stat_set  = 1'b1;
					cmd.stat_code = ST_DUP;
					state_d       = S_FINISH;
				end else if (stat.full) begin
					cmd.stat_set  = 1'b1;
					cmd.stat_code = ST_FULL;
					state_d       = S_FINISH;
				end else begin
					cmd.idx_op = IDX_CNT;
					state_d    = S_SHUP;
				end
			end else begin
				if (found) begin
					cmd.res_take = 1'b1;
					state_d      = S_SHDN;
				end else begin
					cmd.stat_set  = 1'b1;
					cmd.stat_code = ST_NOTFOUND;
					state_d       = S_FINISH;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
